// ----- rtl/eilc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eilc_pkg
// Shared types and constants of the external interrupt line controller.
// ----------------------------------------------------------------------------
package eilc_pkg;

  localparam int unsigned NUM_LINES = 16;
  localparam int unsigned LINE_W    = 16;
  localparam int unsigned SEL_W     = 4;
  localparam int unsigned IRQ_W     = 7;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 32;

  // Lines that exist
  localparam logic [LINE_W-1:0] LINE_BITS = LINE_W'((17'd1 << NUM_LINES) - 17'd1);

  // Request groups
  localparam logic [LINE_W-1:0] GRP_SINGLE = 16'h001F;
  localparam logic [LINE_W-1:0] GRP_MID    = 16'h03E0;
  localparam logic [LINE_W-1:0] GRP_HIGH   = 16'hFC00;

  typedef enum logic [1:0] {
    OpSample  = 2'd0,
    OpTrigger = 2'd1,
    OpClear   = 2'd2,
    OpStatus  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgRiseEnable = 2'd0,
    CfgFallEnable = 2'd1,
    CfgIrqEnable  = 2'd2,
    CfgPortSelect = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    op_e               opcode;
    logic [SEL_W-1:0]  port_index;
    logic [LINE_W-1:0] pin_levels;
    logic [LINE_W-1:0] line_mask;
  } in_item_t;

  typedef struct packed {
    logic              next_valid;
    logic [SEL_W-1:0]  next_line;
    logic [IRQ_W-1:0]  irq_requests;
    logic [LINE_W-1:0] pending_lines;
  } out_item_t;

endpackage

// ----- rtl/external_interrupt_line_controller_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// external_interrupt_line_controller_core
// Edge-triggered interrupt lines (NUM_LINES in eilc_pkg) with port select, pending, masking.
// ----------------------------------------------------------------------------
// Datapath: input register, then one pass of edge/pending logic into the
//   result register; the pending register is updated in the same pass.
// Throughput: one item per cycle while the result stream is not stalled.
// Reset: asynchronous, clears config registers, last levels, pending bits
//   and both valid flags.
module external_interrupt_line_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [63:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] port_index, [19:4] pin_levels, [35:20] line_mask, [39:36] zero
  input  logic [39:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] pending_lines, [22:16] irq_requests, [26:23] next_line,
  // [27] next_valid, [31:28] zero
  output logic [31:0] m_axis_tdata
);

  logic [eilc_pkg::LINE_W-1:0] rise_en_q, fall_en_q, irq_en_q;
  logic [eilc_pkg::CFG_W-1:0]  port_sel_q;
  logic [eilc_pkg::LINE_W-1:0] last_level_q, last_level_d;
  logic [eilc_pkg::LINE_W-1:0] pending_q, pending_d;

  logic                in_valid_q;
  eilc_pkg::in_item_t  in_q;
  logic                out_valid_q;
  eilc_pkg::out_item_t out_q, out_d;
  logic                advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_en_q  <= '0;
      fall_en_q  <= '0;
      irq_en_q   <= '0;
      port_sel_q <= '0;
    end else if (cfg_we_i) begin
      case (eilc_pkg::cfg_idx_e'(cfg_addr_i))
        eilc_pkg::CfgRiseEnable: rise_en_q  <= cfg_wdata_i[eilc_pkg::LINE_W-1:0];
        eilc_pkg::CfgFallEnable: fall_en_q  <= cfg_wdata_i[eilc_pkg::LINE_W-1:0];
        eilc_pkg::CfgIrqEnable:  irq_en_q   <= cfg_wdata_i[eilc_pkg::LINE_W-1:0];
        eilc_pkg::CfgPortSelect: port_sel_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register; advance whenever the result slot is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.opcode     <= eilc_pkg::op_e'(s_axis_tuser);
      in_q.port_index <= s_axis_tdata[3:0];
      in_q.pin_levels <= s_axis_tdata[19:4];
      in_q.line_mask  <= s_axis_tdata[35:20];
    end
  end

  // Edge detection and pending update
  logic [eilc_pkg::LINE_W-1:0] sel, rising, falling, mask, active;
  logic [eilc_pkg::SEL_W-1:0]  next_line;
  logic                        next_valid;

  always_comb begin
    for (int n = 0; n < eilc_pkg::LINE_W; n++) begin
      sel[n] = (port_sel_q[eilc_pkg::SEL_W*n +: eilc_pkg::SEL_W] == in_q.port_index);
    end
    sel     = sel & eilc_pkg::LINE_BITS;
    rising  = sel & in_q.pin_levels & ~last_level_q;
    falling = sel & ~in_q.pin_levels & last_level_q;
    mask    = in_q.line_mask & eilc_pkg::LINE_BITS;

    pending_d    = pending_q;
    last_level_d = last_level_q;
    case (in_q.opcode)
      eilc_pkg::OpSample: begin
        pending_d    = pending_q | (rising & rise_en_q) | (falling & fall_en_q);
        last_level_d = (last_level_q & ~sel) | (in_q.pin_levels & sel);
      end
      eilc_pkg::OpTrigger: pending_d = pending_q | (mask & irq_en_q);
      eilc_pkg::OpClear:   pending_d = pending_q & ~mask;
      default: ;
    endcase
    pending_d = pending_d & eilc_pkg::LINE_BITS;

    active     = pending_d & irq_en_q & eilc_pkg::LINE_BITS;
    next_line  = '0;
    next_valid = |active;
    // Scan downward so the lowest active line wins
    for (int n = eilc_pkg::LINE_W - 1; n >= 0; n--) begin
      if (active[n]) begin
        next_line = eilc_pkg::SEL_W'(n);
      end
    end

    out_d.pending_lines = pending_d;
    out_d.irq_requests  = {|(active & eilc_pkg::GRP_HIGH),
                           |(active & eilc_pkg::GRP_MID),
                           active[4:0]};
    out_d.next_line     = next_line;
    out_d.next_valid    = next_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= '0;
      last_level_q <= '0;
    end else if (advance) begin
      pending_q    <= pending_d;
      last_level_q <= last_level_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q.next_valid, out_q.next_line,
                          out_q.irq_requests, out_q.pending_lines};

`ifndef NO_ASSERTIONS
  a_next_is_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.next_valid) |-> out_q.pending_lines[out_q.next_line])
    else $error("next_line names a line that is not pending");

  a_valid_matches_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.next_valid == (|out_q.irq_requests)))
    else $error("next_valid disagrees with irq_requests");

  a_state_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_q && out_q.pending_lines == pending_q))
    else $error("reported pending differs from stored pending");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(pending_q) && $stable(last_level_q)))
    else $error("line state changed without an item");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the external interrupt line controller core. Each transaction is
// predicted from shadow copies of the registers, the last seen levels and the
// pending bits. Every result is compared field by field with the oldest
// prediction. Directed cases cover first-sample edges, port routing, masked
// software triggers and the request groups. Random phases follow, each with
// its own register setting; both streams stall at random except in one stall-free stretch.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned LIMIT        = 200000;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned IDLE_PCT     = 26;
  localparam int unsigned NUM_PHASES   = 10;
  localparam int unsigned PHASE_ITEMS  = 60;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [eilc_pkg::CFG_IDX_W-1:0]  cfg_addr_i    = '0;
  logic [eilc_pkg::CFG_W-1:0]      cfg_wdata_i   = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [eilc_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]                      s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [eilc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // shadow state of the controller
  logic [eilc_pkg::LINE_W-1:0] pred_rise  = '0;
  logic [eilc_pkg::LINE_W-1:0] pred_fall  = '0;
  logic [eilc_pkg::LINE_W-1:0] pred_irq   = '0;
  logic [eilc_pkg::CFG_W-1:0]  pred_psel  = '0;
  logic [eilc_pkg::LINE_W-1:0] pred_level = '0;
  logic [eilc_pkg::LINE_W-1:0] pred_pend  = '0;

  eilc_pkg::out_item_t status_due[$];
  logic        idle_on    = 1'b1;
  int unsigned cycles     = 0;
  int unsigned n_fail     = 0;
  int unsigned n_items    = 0;
  int unsigned n_results  = 0;
  int unsigned n_settings = 0;

  external_interrupt_line_controller_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Apply one transaction to the shadow state and work out its status.
  task automatic update_lines(input eilc_pkg::op_e op,
                              input logic [eilc_pkg::SEL_W-1:0] port,
                              input logic [eilc_pkg::LINE_W-1:0] pins,
                              input logic [eilc_pkg::LINE_W-1:0] mask,
                              output eilc_pkg::out_item_t res);
    logic [eilc_pkg::LINE_W-1:0] sel;
    logic [eilc_pkg::LINE_W-1:0] active;
    sel = '0;
    for (int n = 0; n < eilc_pkg::NUM_LINES; n++) begin
      if (pred_psel[eilc_pkg::SEL_W*n +: eilc_pkg::SEL_W] == port) sel[n] = 1'b1;
    end
    case (op)
      eilc_pkg::OpSample: begin
        pred_pend  |= (sel & pins & ~pred_level & pred_rise) |
                      (sel & ~pins & pred_level & pred_fall);
        pred_level  = (pred_level & ~sel) | (pins & sel);
      end
      eilc_pkg::OpTrigger: pred_pend |= mask & pred_irq;
      eilc_pkg::OpClear:   pred_pend &= ~mask;
      default: ;
    endcase
    pred_pend &= eilc_pkg::LINE_BITS;
    active = pred_pend & pred_irq & eilc_pkg::LINE_BITS;
    res = '0;
    res.pending_lines = pred_pend;
    res.irq_requests  = {|(active & eilc_pkg::GRP_HIGH), |(active & eilc_pkg::GRP_MID),
                         active[4:0]};
    // scan downward so the lowest active line wins
    for (int n = eilc_pkg::LINE_W - 1; n >= 0; n--) begin
      if (active[n]) begin
        res.next_line  = eilc_pkg::SEL_W'(n);
        res.next_valid = 1'b1;
      end
    end
  endtask

  task automatic send_item(input eilc_pkg::op_e op,
                           input logic [eilc_pkg::SEL_W-1:0] port,
                           input logic [eilc_pkg::LINE_W-1:0] pins,
                           input logic [eilc_pkg::LINE_W-1:0] mask);
    eilc_pkg::out_item_t res;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'd0, mask, pins, port};
    do @(posedge clk_i); while (!s_axis_tready);
    update_lines(op, port, pins, mask, res);
    status_due.push_back(res);
    n_items++;
  endtask

  // Drop valid, wait for every outstanding status, then let the pipe empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input eilc_pkg::cfg_idx_e idx,
                           input logic [eilc_pkg::CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      eilc_pkg::CfgRiseEnable: pred_rise = val[eilc_pkg::LINE_W-1:0];
      eilc_pkg::CfgFallEnable: pred_fall = val[eilc_pkg::LINE_W-1:0];
      eilc_pkg::CfgIrqEnable:  pred_irq  = val[eilc_pkg::LINE_W-1:0];
      eilc_pkg::CfgPortSelect: pred_psel = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [eilc_pkg::LINE_W-1:0] rise,
                           input logic [eilc_pkg::LINE_W-1:0] fall,
                           input logic [eilc_pkg::LINE_W-1:0] irq,
                           input logic [eilc_pkg::CFG_W-1:0] psel);
    write_reg(eilc_pkg::CfgRiseEnable, eilc_pkg::CFG_W'(rise));
    write_reg(eilc_pkg::CfgFallEnable, eilc_pkg::CFG_W'(fall));
    write_reg(eilc_pkg::CfgIrqEnable, eilc_pkg::CFG_W'(irq));
    write_reg(eilc_pkg::CfgPortSelect, psel);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (status_due.size() == 0) begin
        $error("result with no transaction waiting: tdata %h", m_axis_tdata);
        n_fail++;
      end else begin
        eilc_pkg::out_item_t want;
        eilc_pkg::out_item_t got;
        want = status_due.pop_front();
        got  = m_axis_tdata[27:0];
        n_results++;
        if (got.pending_lines !== want.pending_lines) begin
          $error("pending_lines: expected %h, got %h", want.pending_lines, got.pending_lines);
          n_fail++;
        end
        if (got.irq_requests !== want.irq_requests) begin
          $error("irq_requests: expected %h, got %h", want.irq_requests, got.irq_requests);
          n_fail++;
        end
        if (got.next_line !== want.next_line) begin
          $error("next_line: expected %0d, got %0d", want.next_line, got.next_line);
          n_fail++;
        end
        if (got.next_valid !== want.next_valid) begin
          $error("next_valid: expected %b, got %b", want.next_valid, got.next_valid);
          n_fail++;
        end
      end
    end
  end

  // Pins start low, so a high pin on its first sample is a rising edge.
  task automatic test_first_samples();
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, '0);
    send_item(eilc_pkg::OpSample, 4'd0, 16'hFFFF, 16'h0000);
    send_item(eilc_pkg::OpStatus, 4'd0, 16'h0000, 16'h0000);
    send_item(eilc_pkg::OpClear, 4'd0, 16'h0000, 16'hFFFF);
    send_item(eilc_pkg::OpSample, 4'd0, 16'h0000, 16'h0000);
    send_item(eilc_pkg::OpClear, 4'd0, 16'h0000, 16'hFFFF);
    // no line selects port 9: nothing may change
    send_item(eilc_pkg::OpSample, 4'd9, 16'hFFFF, 16'h0000);
    settle();
  endtask

  task automatic test_port_routing();
    configure(16'h00FF, 16'hFF00, 16'hFFFF, 64'hFEDC_BA98_7654_3210);
    send_item(eilc_pkg::OpSample, 4'd15, 16'h8000, 16'h0000);
    send_item(eilc_pkg::OpSample, 4'd15, 16'h0000, 16'h0000);
    send_item(eilc_pkg::OpSample, 4'd3, 16'hFFFF, 16'h0000);
    send_item(eilc_pkg::OpSample, 4'd0, 16'h0001, 16'h0000);
    send_item(eilc_pkg::OpClear, 4'd0, 16'h0000, 16'hFFFF);
    settle();
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, '1);
    send_item(eilc_pkg::OpSample, 4'd15, 16'hA5A5, 16'h0000);
    send_item(eilc_pkg::OpSample, 4'd15, 16'h5A5A, 16'h0000);
    settle();
  endtask

  // Triggers only land on lines whose interrupt is enabled.
  task automatic test_trigger_masking();
    configure(16'h0000, 16'h0000, 16'h8421, '0);
    send_item(eilc_pkg::OpTrigger, 4'd0, 16'h0000, 16'hFFFF);
    send_item(eilc_pkg::OpClear, 4'd0, 16'h0000, 16'h0001);
    send_item(eilc_pkg::OpTrigger, 4'd0, 16'h0000, 16'h0000);
    send_item(eilc_pkg::OpClear, 4'd0, 16'h0000, 16'h0000);
    send_item(eilc_pkg::OpClear, 4'd0, 16'h0000, 16'hFFFF);
    send_item(eilc_pkg::OpStatus, 4'd15, 16'hFFFF, 16'hFFFF);
    settle();
  endtask

  task automatic test_request_groups();
    configure(16'h0000, 16'h0000, 16'hFFFF, '0);
    send_item(eilc_pkg::OpTrigger, 4'd0, 16'h0000, 16'h0020);
    send_item(eilc_pkg::OpTrigger, 4'd0, 16'h0000, 16'h8000);
    send_item(eilc_pkg::OpClear, 4'd0, 16'h0000, 16'h0020);
    send_item(eilc_pkg::OpTrigger, 4'd0, 16'h0000, 16'h0010);
    send_item(eilc_pkg::OpClear, 4'd0, 16'h0000, 16'hFFFF);
    settle();
  endtask

  function automatic logic [eilc_pkg::LINE_W-1:0] pick_enable();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 40) return '1;
    return eilc_pkg::LINE_W'($urandom);
  endfunction

  task automatic test_random_phases();
    logic [eilc_pkg::SEL_W-1:0]  hot [4];
    logic [eilc_pkg::SEL_W-1:0]  port;
    logic [eilc_pkg::LINE_W-1:0] pins;
    logic [eilc_pkg::LINE_W-1:0] mask;
    logic [eilc_pkg::LINE_W-1:0] port_pins [16];
    logic [eilc_pkg::CFG_W-1:0]  psel;
    int unsigned                 k;
    int unsigned                 r;
    eilc_pkg::op_e               op;
    for (int p = 0; p < 16; p++) port_pins[p] = '0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // keep one long stretch free of stalls on both streams
      idle_on = !(phase == 4 || phase == 5);
      k = $urandom_range(1, 4);
      for (int h = 0; h < 4; h++) begin
        hot[h] = (phase == 1) ? 4'hF : (phase == 2) ? 4'h0 : eilc_pkg::SEL_W'($urandom);
      end
      // cluster lines on a few ports so samples hit selected lines
      for (int n = 0; n < eilc_pkg::NUM_LINES; n++) begin
        psel[eilc_pkg::SEL_W*n +: eilc_pkg::SEL_W] = hot[$urandom_range(0, k - 1)];
      end
      configure(pick_enable(), pick_enable(), pick_enable(), psel);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r    = $urandom_range(0, 99);
        op   = (r < 55) ? eilc_pkg::OpSample :
               (r < 70) ? eilc_pkg::OpTrigger :
               (r < 90) ? eilc_pkg::OpClear : eilc_pkg::OpStatus;
        port = ($urandom_range(0, 99) < 85) ? hot[$urandom_range(0, k - 1)]
                                            : eilc_pkg::SEL_W'($urandom);
        pins = ($urandom_range(0, 1) != 0) ? eilc_pkg::LINE_W'($urandom)
               : port_pins[port] ^ eilc_pkg::LINE_W'($urandom & $urandom);
        r    = $urandom_range(0, 99);
        mask = (r < 50) ? eilc_pkg::LINE_W'($urandom) :
               (r < 80) ? eilc_pkg::LINE_W'(1 << $urandom_range(0, 15)) : 16'hFFFF;
        if (op == eilc_pkg::OpSample) port_pins[port] = pins;
        send_item(op, port, pins, mask);
      end
      settle();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_samples();
    test_port_routing();
    test_trigger_masking();
    test_request_groups();
    test_random_phases();
    settle();
    $display("Ran %0d transactions (samples, triggers, clears, status); %0d results checked.",
             n_items, n_results);
    $display("Used %0d register settings, all-zero and all-one values among them.",
             n_settings);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
